@@ rtl/sorted_table_insert_delete_core_defines.svh @@
// ---------------------------------------------------------------------------
// Sorted table assertion macros
// Clocked assertion helpers for the sorted key table; they are empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_TABLE_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every edge outside reset.
`define STID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define STID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STID_ASSERT(lbl, prop, msg)
`define STID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/stid_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted table package
// Sizes, codes and the command bundle shared by the table cells and the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stid_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_WIDTH  = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_PORT_W = 32;
  localparam int CNT_PORT_W = 5;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    op_e  op;
    key_t key;
    logic apply;
  } cell_cmd_t;

endpackage

@@ rtl/stid_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted table cell
// Holds one key, compares it with the command key and shifts toward a neighbor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stid_cell import stid_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      occupied_i,
  input  key_t      left_key_i,
  input  logic      left_le_i,
  input  logic      left_seen_i,
  input  key_t      right_key_i,
  output key_t      key_o,
  output logic      le_o,
  output logic      seen_o
);

  key_t key_q;
  key_t key_d;

  assign le_o   = occupied_i && (key_q <= cmd_i.key);
  // The first match and every cell behind it close the gap on a delete.
  assign seen_o = left_seen_i || (occupied_i && (key_q == cmd_i.key));
  assign key_o  = key_q;

  always_comb begin
    key_d = key_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (!le_o) begin
          key_d = left_le_i ? cmd_i.key : left_key_i;
        end
      end
      OP_DELETE: begin
        if (seen_o) begin
          key_d = right_key_i;
        end
      end
      default: begin
        key_d = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      key_q <= key_d;
    end
  end

endmodule

@@ rtl/sorted_table_insert_delete_core.sv @@
// ---------------------------------------------------------------------------
// Sorted table insert and delete core
// Keeps up to sixteen keys in ascending order in a row of cells and takes one
// insert or delete command in every clock cycle; busy_o never rises. Each
// command gives one result beat on done_o exactly one cycle after it is
// accepted, and that beat cannot be held off, so the receiver must take it.
// The one-cycle figure is set by the cell row: every cell compares its key
// with the command key in parallel and loads its own or a neighbor's key in
// the same edge. No clearing pass follows reset; the table starts empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_insert_delete_core_defines.svh"

module sorted_table_insert_delete_core import stid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  opcode_i,
  input  logic [KEY_PORT_W-1:0] key_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [CNT_PORT_W-1:0] entry_count_o,
  output logic [KEY_PORT_W-1:0] smallest_key_o
);

  cell_cmd_t cmd;
  logic      accept;
  logic      full;
  logic      found;
  key_t      key_w  [CAPACITY];
  logic      le_w   [CAPACITY];
  logic      seen_w [CAPACITY];

  cnt_t    count_q;
  cnt_t    count_d;
  logic    done_q;
  status_e status_q;
  status_e status_d;

  // The row finishes a command in the cycle it is taken.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(CAPACITY));
  assign found  = seen_w[CAPACITY-1];

  assign cmd.op    = op_e'(opcode_i);
  assign cmd.key   = KEY_WIDTH'(key_i);
  assign cmd.apply = accept && ((cmd.op == OP_DELETE) || !full);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    logic left_le;
    logic left_seen;
    key_t right_key;

    if (i == 0) begin : g_head
      assign left_key  = cmd.key;
      assign left_le   = 1'b1;
      assign left_seen = 1'b0;
    end else begin : g_body
      assign left_key  = key_w[i-1];
      assign left_le   = le_w[i-1];
      assign left_seen = seen_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = key_w[i];
    end else begin : g_mid
      assign right_key = key_w[i+1];
    end

    stid_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (CNT_W'(i) < count_q),
      .left_key_i (left_key),
      .left_le_i  (left_le),
      .left_seen_i(left_seen),
      .right_key_i(right_key),
      .key_o      (key_w[i]),
      .le_o       (le_w[i]),
      .seen_o     (seen_w[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    case (cmd.op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (found) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q  <= count_d;
        status_q <= status_d;
      end
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign entry_count_o  = CNT_PORT_W'(count_q);
  assign smallest_key_o = (count_q != '0) ? KEY_PORT_W'(key_w[0]) : '0;

  `STID_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
  `STID_ASSERT_NEXT(a_done_follows, accept, done_o, "accepted command gave no result beat")
  `STID_ASSERT(a_full_at_cap,
               !(done_o && status_o == ST_FULL) || full,
               "full reported below capacity")
  `STID_ASSERT(a_refused_holds,
               !(done_o && status_o != ST_DONE) || count_q == $past(count_q),
               "refused command changed the count")

endmodule
